// ===== hdl/ccma_pkg.sv =====
package ccma_pkg;

   localparam int MAX_POINTS = 32;
   localparam int MAX_HALF_WINDOW = 15;
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int COORD_W = 16;
   localparam int HW_W = 4;
   localparam int DIV_W = HW_W + 1;
   // A window of up to 31 terms of 16-bit signed values needs 21 bits.
   localparam int SUM_W = COORD_W + DIV_W;
   // Magnitude of the sum plus half the divisor still fits below 2^20.
   localparam int DIVIDEND_W = SUM_W - 1;
   localparam int STEP_W = $clog2(DIVIDEND_W);
   localparam int PAIR_W = 2 * COORD_W;

   typedef struct packed {
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic                      last_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] smooth_x;
      logic signed [COORD_W-1:0] smooth_y;
      logic                      end_of_contour;
      logic                      overflow;
   } rsp_type;

endpackage

// ===== hdl/ccma_ram.sv =====
module ccma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ccma_div.sv =====
module ccma_div import ccma_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_W-1:0]      divisor,
   input  logic [DIVIDEND_W-1:0] dividend_x,
   input  logic [DIVIDEND_W-1:0] dividend_y,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quot_x,
   output logic [DIVIDEND_W-1:0] quot_y
);

   // Restoring division, one quotient bit per cycle for both lanes.
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIV_W-1:0]      div_ff, div_in;
   logic [DIVIDEND_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [DIV_W-1:0]      rx_ff, rx_in, ry_ff, ry_in;
   logic [DIV_W:0]        trial_x, trial_y;
   logic                  ge_x, ge_y;

   always_comb begin
      trial_x = {rx_ff, qx_ff[DIVIDEND_W-1]};
      trial_y = {ry_ff, qy_ff[DIVIDEND_W-1]};
      ge_x = trial_x >= {1'b0, div_ff};
      ge_y = trial_y >= {1'b0, div_ff};
      run_in = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      div_in = div_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      if (start) begin
         run_in = 1'b1;
         step_in = '0;
         div_in = divisor;
         qx_in = dividend_x;
         qy_in = dividend_y;
         rx_in = '0;
         ry_in = '0;
      end else if (run_ff) begin
         rx_in = ge_x ? DIV_W'(trial_x - {1'b0, div_ff}) : trial_x[DIV_W-1:0];
         ry_in = ge_y ? DIV_W'(trial_y - {1'b0, div_ff}) : trial_y[DIV_W-1:0];
         qx_in = {qx_ff[DIVIDEND_W-2:0], ge_x};
         qy_in = {qy_ff[DIVIDEND_W-2:0], ge_y};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      div_ff <= div_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
   end

   assign done = done_ff;
   assign quot_x = qx_ff;
   assign quot_y = qy_ff;

endmodule

// ===== hdl/closed_contour_moving_average_unit.sv =====
// Closed contour moving average unit. Points of one contour are loaded one
// transfer per cycle through start/busy; each is taken in a single cycle, and
// up to 32 points are held. The point flagged last_point starts the output:
// every held point is replaced by the rounded mean of the 2h+1 points centered
// on it (h from the half_window register, indices wrapping around the
// contour), then the first smoothed point is sent again with end_of_contour
// set. Points beyond 32 are dropped and every result of that contour carries
// overflow. Results appear on rsp_data for exactly one cycle, marked by
// rsp_valid, and cannot be stalled: the receiver must take every transfer.
// After the last point is accepted the unit stays busy while it smooths the
// contour: the single read port of the point memory takes one window term per
// cycle, and the shared divider produces one quotient bit per cycle for each
// point. half_window may be written whenever busy is low; it resets to 1.
module closed_contour_moving_average_unit import ccma_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_type         req_data,
   output logic            rsp_valid,
   output rsp_type         rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [HW_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_ACC,
      ST_LAST,
      ST_SETUP,
      ST_DIV,
      ST_CLOSE
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      dropped_ff, dropped_in;
   logic [HW_W-1:0]           hw_ff, hw_in;
   logic [HW_W-1:0]           align_ff, align_in;
   logic [ADDR_W-1:0]         base_ff, base_in;
   logic [ADDR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [DIV_W-1:0]          issue_ff, issue_in;
   logic [CNT_W-1:0]          point_ff, point_in;
   logic signed [SUM_W-1:0]   sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic                      neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [COORD_W-1:0]        first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic [CNT_W-1:0]          last_idx;
   logic [ADDR_W-1:0]         base_inc, base_dec, rd_inc;
   logic [DIV_W-1:0]          divisor;
   logic                      wr_en;
   logic [PAIR_W-1:0]         rd_data;
   logic signed [SUM_W-1:0]   term_x, term_y;
   logic signed [SUM_W-1:0]   mag_x, mag_y;
   logic                      div_start, div_done;
   logic [DIVIDEND_W-1:0]     dividend_x, dividend_y, quot_x, quot_y;
   logic [COORD_W-1:0]        mean_x, mean_y;

   // The divisor is the window size 2h+1, and half of it rounded down is h.
   assign divisor = {hw_ff, 1'b1};
   assign last_idx = count_ff - CNT_W'(1);

   // Pointer steps that wrap around the contour of count_ff points.
   assign base_inc = ({1'b0, base_ff} == last_idx) ? '0 : base_ff + ADDR_W'(1);
   assign base_dec = (base_ff == '0) ? last_idx[ADDR_W-1:0] : base_ff - ADDR_W'(1);
   assign rd_inc = ({1'b0, rd_ptr_ff} == last_idx) ? '0 : rd_ptr_ff + ADDR_W'(1);

   assign wr_en = (state_ff == ST_IDLE) && start && (count_ff < CNT_W'(MAX_POINTS));

   ccma_ram #(
      .WIDTH(PAIR_W),
      .DEPTH(MAX_POINTS)
   ) u_points (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data({req_data.coord_x, req_data.coord_y}),
      .rd_addr(rd_ptr_ff),
      .rd_data(rd_data)
   );

   assign term_x = {{(SUM_W-COORD_W){rd_data[PAIR_W-1]}}, rd_data[PAIR_W-1:COORD_W]};
   assign term_y = {{(SUM_W-COORD_W){rd_data[COORD_W-1]}}, rd_data[COORD_W-1:0]};

   // Round half away from zero: divide |sum| + h by 2h+1 and restore the sign.
   assign mag_x = sum_x_ff[SUM_W-1] ? -sum_x_ff : sum_x_ff;
   assign mag_y = sum_y_ff[SUM_W-1] ? -sum_y_ff : sum_y_ff;
   assign dividend_x = mag_x[DIVIDEND_W-1:0] + DIVIDEND_W'(hw_ff);
   assign dividend_y = mag_y[DIVIDEND_W-1:0] + DIVIDEND_W'(hw_ff);
   assign div_start = (state_ff == ST_SETUP);

   ccma_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .divisor   (divisor),
      .dividend_x(dividend_x),
      .dividend_y(dividend_y),
      .done      (div_done),
      .quot_x    (quot_x),
      .quot_y    (quot_y)
   );

   assign mean_x = neg_x_ff ? -quot_x[COORD_W-1:0] : quot_x[COORD_W-1:0];
   assign mean_y = neg_y_ff ? -quot_y[COORD_W-1:0] : quot_y[COORD_W-1:0];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      dropped_in = dropped_ff;
      hw_in = hw_ff;
      align_in = align_ff;
      base_in = base_ff;
      rd_ptr_in = rd_ptr_ff;
      issue_in = issue_ff;
      point_in = point_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      neg_x_in = neg_x_ff;
      neg_y_in = neg_y_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;

      if (csr_valid && csr_ready) begin
         hw_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            // One point per transfer; a point past capacity is not stored and marks overflow.
            if (start) begin
               if (count_ff < CNT_W'(MAX_POINTS)) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.last_point) begin
                  state_in = ST_ALIGN;
                  base_in = '0;
                  // A register write in this same cycle already applies to
                  // this contour, so the window start follows the new value.
                  align_in = hw_in;
                  point_in = '0;
               end
            end
         end
         ST_ALIGN: begin
            // Walk the window start back h places from point zero, wrapping.
            if (align_ff == '0) begin
               state_in = ST_ACC;
               rd_ptr_in = base_ff;
               issue_in = '0;
               sum_x_in = '0;
               sum_y_in = '0;
            end else begin
               base_in = base_dec;
               align_in = align_ff - HW_W'(1);
            end
         end
         ST_ACC: begin
            // One read issued per cycle; data of the previous read is summed.
            if (issue_ff != '0) begin
               sum_x_in = sum_x_ff + term_x;
               sum_y_in = sum_y_ff + term_y;
            end
            rd_ptr_in = rd_inc;
            issue_in = issue_ff + DIV_W'(1);
            if (issue_ff == DIV_W'(divisor - DIV_W'(1))) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            sum_x_in = sum_x_ff + term_x;
            sum_y_in = sum_y_ff + term_y;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            neg_x_in = sum_x_ff[SUM_W-1];
            neg_y_in = sum_y_ff[SUM_W-1];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_in.smooth_x = mean_x;
               rsp_in.smooth_y = mean_y;
               rsp_in.end_of_contour = 1'b0;
               rsp_in.overflow = dropped_ff;
               if (point_ff == '0) begin
                  first_x_in = mean_x;
                  first_y_in = mean_y;
               end
               if (point_ff == last_idx) begin
                  state_in = ST_CLOSE;
               end else begin
                  state_in = ST_ACC;
                  point_in = point_ff + CNT_W'(1);
                  base_in = base_inc;
                  rd_ptr_in = base_inc;
                  issue_in = '0;
                  sum_x_in = '0;
                  sum_y_in = '0;
               end
            end
         end
         ST_CLOSE: begin
            // Repeat the first smoothed point to close the contour.
            rsp_valid_in = 1'b1;
            rsp_in.smooth_x = first_x_ff;
            rsp_in.smooth_y = first_y_ff;
            rsp_in.end_of_contour = 1'b1;
            rsp_in.overflow = dropped_ff;
            count_in = '0;
            dropped_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         dropped_ff <= 1'b0;
         hw_ff <= HW_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         dropped_ff <= dropped_in;
         hw_ff <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      align_ff <= align_in;
      base_ff <= base_in;
      rd_ptr_ff <= rd_ptr_in;
      issue_ff <= issue_in;
      point_ff <= point_in;
      sum_x_ff <= sum_x_in;
      sum_y_ff <= sum_y_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== tb/closed_contour_moving_average_checker.sv =====
module closed_contour_moving_average_checker import ccma_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            busy,
   input  req_type         req_data,
   input  logic            rsp_valid,
   input  rsp_type         rsp_data,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [HW_W-1:0] csr_data,
   output int              mismatch_count,
   output int              pending_results
);

   localparam int MAX_REPORTS = 40;

   logic signed [COORD_W-1:0] held_x [MAX_POINTS];
   logic signed [COORD_W-1:0] held_y [MAX_POINTS];
   int                        held_count = 0;
   logic                      points_dropped = 1'b0;
   logic [HW_W-1:0]           window_half = 4'd1;
   rsp_type                   smoothed_q [$];
   int                        fail_total = 0;

   task automatic report_mismatch(input string what);
      if (fail_total < MAX_REPORTS)
         $display("%0t: mismatch: %s", $time, what);
      fail_total++;
   endtask

   // Rounded to nearest, ties away from zero.
   function automatic int round_div(input int sum, input int divisor);
      if (sum >= 0)
         return (sum + divisor / 2) / divisor;
      return -((-sum + divisor / 2) / divisor);
   endfunction

   // Queues the smoothed contour plus the closing repeat of its first point.
   task automatic smooth_contour();
      int      h;
      int      divisor;
      int      sum_x;
      int      sum_y;
      int      k;
      rsp_type pt;
      rsp_type first_pt;
      h = int'(window_half);
      if (h > MAX_HALF_WINDOW)
         h = MAX_HALF_WINDOW;
      divisor = 2 * h + 1;
      first_pt = '0;
      for (int i = 0; i < held_count; i++) begin
         sum_x = 0;
         sum_y = 0;
         for (int j = -h; j <= h; j++) begin
            k = ((i + j) % held_count + held_count) % held_count;
            sum_x += held_x[k];
            sum_y += held_y[k];
         end
         pt.smooth_x = COORD_W'(round_div(sum_x, divisor));
         pt.smooth_y = COORD_W'(round_div(sum_y, divisor));
         pt.end_of_contour = 1'b0;
         pt.overflow = points_dropped;
         if (i == 0)
            first_pt = pt;
         smoothed_q.insert(smoothed_q.size(), pt);
      end
      first_pt.end_of_contour = 1'b1;
      smoothed_q.insert(smoothed_q.size(), first_pt);
      held_count = 0;
      points_dropped = 1'b0;
   endtask

   task automatic take_point();
      if (held_count < MAX_POINTS) begin
         held_x[held_count] = req_data.coord_x;
         held_y[held_count] = req_data.coord_y;
         held_count++;
      end else begin
         points_dropped = 1'b1;
      end
      if (req_data.last_point)
         smooth_contour();
   endtask

   task automatic check_result();
      rsp_type want;
      if (smoothed_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result x=%0d y=%0d end=%0b ovf=%0b",
            rsp_data.smooth_x, rsp_data.smooth_y, rsp_data.end_of_contour,
            rsp_data.overflow));
         return;
      end
      want = smoothed_q.pop_front();
      if (rsp_data.smooth_x !== want.smooth_x)
         report_mismatch($sformatf("smooth_x got %0d want %0d",
            rsp_data.smooth_x, want.smooth_x));
      if (rsp_data.smooth_y !== want.smooth_y)
         report_mismatch($sformatf("smooth_y got %0d want %0d",
            rsp_data.smooth_y, want.smooth_y));
      if (rsp_data.end_of_contour !== want.end_of_contour)
         report_mismatch($sformatf("end_of_contour got %0b want %0b",
            rsp_data.end_of_contour, want.end_of_contour));
      if (rsp_data.overflow !== want.overflow)
         report_mismatch($sformatf("overflow got %0b want %0b",
            rsp_data.overflow, want.overflow));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         points_dropped = 1'b0;
         window_half = 4'd1;
         smoothed_q.delete();
      end else begin
         if (rsp_valid)
            check_result();
         if (csr_valid && csr_ready)
            window_half = csr_data;
         if (start && !busy)
            take_point();
      end
      mismatch_count <= fail_total;
      pending_results <= smoothed_q.size();
   end

endmodule

// ===== tb/closed_contour_moving_average_unit_tb.sv =====
module closed_contour_moving_average_unit_tb;
   import ccma_pkg::*;

   // The slowest legal run stays far below this: about 200 points, each
   // costing the most busy time at the widest window, plus sender gaps and
   // the settle pauses around each register write.
   localparam int CYCLE_LIMIT = 400000;
   // Quiet cycles allowed after the last result before the register is
   // written or the verdict is given; the unit drops busy in the same cycle
   // that the closing point of a contour appears.
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_ITEMS = 150;

   localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   req_type         req_data = '0;
   logic            csr_valid = 1'b0;
   logic [HW_W-1:0] csr_data = '0;
   logic            busy;
   logic            rsp_valid;
   rsp_type         rsp_data;
   logic            csr_ready;

   int mismatch_count;
   int pending_results;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int items_sent = 0;

   closed_contour_moving_average_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // The checker watches every transfer on all three channels, keeps its own
   // copy of the contour store and the window register, and compares each
   // result with the oldest smoothed point it predicted.
   closed_contour_moving_average_checker smoothing_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offers one point and holds it until the unit takes the transfer. Before
   // offering, the sender may sit idle for a few cycles, each cycle idle with
   // the chance given by sender_idle_pct. The start line is only lowered when
   // at least one idle cycle follows, so it never gets two updates in one
   // time step.
   task automatic send_point(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic last);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      start <= 1'b1;
      req_data <= '{coord_x: x, coord_y: y, last_point: last};
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // The pending count from the checker is updated at the clock edge, so the
   // task always waits for an edge before it trusts the count.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   // The window register is only written with the unit idle: every predicted
   // result has come out and the unit has had time to drop busy.
   task automatic write_half_window(input logic [HW_W-1:0] value);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Full-range values dominate so every bit toggles, with the extremes and
   // small values near zero mixed in to exercise rounding of negative sums.
   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2, 3: return COORD_W'(int'($urandom_range(0, 64)) - 32);
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [HW_W-1:0] random_half_window();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return HW_W'(MAX_HALF_WINDOW);
         default: return HW_W'($urandom_range(0, MAX_HALF_WINDOW));
      endcase
   endfunction

   // Most contours are short to keep the run quick; some fill the store and
   // some overrun it so that points, including the one marked last, are
   // dropped.
   function automatic int random_contour_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return $urandom_range(1, 8);
      if (roll < 85)
         return $urandom_range(9, MAX_POINTS);
      return $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4);
   endfunction

   task automatic send_contour(input int len);
      for (int i = 0; i < len; i++)
         send_point(random_coord(), random_coord(), i == len - 1);
   endtask

   initial begin
      int idle_pct [3];
      int forced_len [3];
      logic [HW_W-1:0] phase_window [3];
      idle_pct = '{32, 82, 0};
      forced_len = '{MAX_POINTS + 1, MAX_POINTS, MAX_POINTS + 3};
      phase_window = '{'0, HW_W'(MAX_HALF_WINDOW), 4'd5};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed contours. The first two run at the reset window of one
      // point each side: a single-point contour and a two-point contour at
      // the coordinate extremes.
      send_point(COORD_MIN, COORD_MAX, 1'b1);
      send_point(COORD_MAX, COORD_MIN, 1'b0);
      send_point(COORD_MIN, COORD_MAX, 1'b1);

      // A window of 31 points over a contour of three wraps many times.
      write_half_window(HW_W'(MAX_HALF_WINDOW));
      send_point(COORD_MAX, COORD_MAX, 1'b0);
      send_point(COORD_MAX, COORD_MIN, 1'b0);
      send_point(-16'sd1, 16'sd1, 1'b1);

      // No averaging at all: each point must come back unchanged.
      write_half_window('0);
      send_point(COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MAX, 1'b0);
      send_point(-16'sd17, 16'sd5, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b1);

      // Small mixed-sign values where rounding direction matters.
      write_half_window(4'd7);
      send_point(-16'sd5, 16'sd7, 1'b0);
      send_point(-16'sd3, -16'sd2, 1'b0);
      send_point(16'sd1, -16'sd1, 1'b0);
      send_point(-16'sd8, 16'sd8, 1'b0);
      send_point(16'sd2, -16'sd6, 1'b1);

      // Widest window over points alternating between the two extremes.
      write_half_window(HW_W'(MAX_HALF_WINDOW));
      for (int i = 0; i < 8; i++)
         send_point((i % 2) ? COORD_MAX : COORD_MIN, (i % 2) ? COORD_MIN : COORD_MAX,
                    i == 7);

      // Random contours in three phases with different sender idling. Each
      // phase opens with a contour of a chosen length around the capacity
      // limit, and now and then the sender holds off until the unit has
      // drained, sometimes writing a new window in between.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = idle_pct[phase];
         write_half_window(phase_window[phase]);
         send_contour(forced_len[phase]);
         while (items_sent < RANDOM_ITEMS * (phase + 1) / 3) begin
            send_contour(random_contour_length());
            if ($urandom_range(0, 3) == 0) begin
               if ($urandom_range(0, 1))
                  write_half_window(random_half_window());
               else
                  wait_for_drain();
            end
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
